### src/rgsi_pkg.sv
// Package for the rotated grid source index block: word types, config
// register layout, register indexes and reset values.
// No dependencies; every module of the block imports it.
package rgsi_pkg;

  localparam int COORD_W   = 13;
  localparam int ROT_W     = 54;
  localparam int COEF_W    = 18;
  localparam int SPC_W     = 60;
  localparam int SPC_F_W   = 20;
  localparam int OFS_W     = 63;
  localparam int OFS_F_W   = 21;
  localparam int DIMS_W    = 39;
  localparam int INDEX_W   = 36;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 63;

  localparam int MAX_OLD_DIM_DEF = 4096;
  localparam int MAX_NEW_DIM     = 8192;

  // Datapath widths.
  localparam int P_W    = 35;   // scaled and shifted point, Q.12 signed
  localparam int PR_W   = 53;   // coefficient times point
  localparam int R_W    = 55;   // rotated point, Q.28 signed
  localparam int MAG_W  = 54;   // magnitude of rotated point
  localparam int LO_SPLIT = 32;
  localparam int LO_W   = LO_SPLIT + SPC_F_W;
  localparam int HI_W   = (MAG_W - LO_SPLIT) + SPC_F_W;
  localparam int FULL_W = MAG_W + SPC_F_W;
  localparam int FRAC_W = 40;
  localparam int Q_W    = FULL_W - FRAC_W + 1;

  // Register stages from accept to result strobe: map 3, scale 2, index 3.
  localparam int PIPE_LAT = 8;

  localparam logic [ROT_W-1:0]  ROT_ROW_X_RST = 54'd65536;
  localparam logic [ROT_W-1:0]  ROT_ROW_Y_RST = 54'd17179869184;
  localparam logic [ROT_W-1:0]  ROT_ROW_Z_RST = 54'd4503599627370496;
  localparam logic [SPC_W-1:0]  NEW_SPC_RST   = 60'd4503603922341888;
  localparam logic [OFS_W-1:0]  NEW_OFS_RST   = '0;
  localparam logic [SPC_W-1:0]  OLD_INV_RST   = 60'd4503603922341888;
  localparam logic [DIMS_W-1:0] OLD_DIMS_RST  = 39'd67117057;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW_X,
    CFG_ROT_ROW_Y,
    CFG_ROT_ROW_Z,
    CFG_NEW_SPACING,
    CFG_NEW_OFFSET,
    CFG_OLD_INV_SPACING,
    CFG_OLD_DIMS,
    CFG_SLICE_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic [ROT_W-1:0]  rot_row_x;
    logic [ROT_W-1:0]  rot_row_y;
    logic [ROT_W-1:0]  rot_row_z;
    logic [SPC_W-1:0]  new_spacing;
    logic [OFS_W-1:0]  new_offset;
    logic [SPC_W-1:0]  old_inv_spacing;
    logic [DIMS_W-1:0] old_dims;
    logic              slice_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_plane;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] source_index;
  } out_word_t;

  // Sideband that rides along the arithmetic stages.
  typedef struct packed {
    logic               new_ok;
    logic [COORD_W-1:0] plane;
  } side_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    side_t                 side;
  } map_word_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          neg;
    side_t               side;
  } scale_word_t;

endpackage

### src/rgsi_map.sv
// Front three stages: scale and offset the output coordinate, multiply by the
// inverse rotation matrix, sum each row and split into sign and magnitude.
// Depends on rgsi_pkg.
module rgsi_map (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rgsi_pkg::in_word_t    in_word,
  input  rgsi_pkg::cfg_regs_t   cfg,
  output logic                  out_valid,
  output rgsi_pkg::map_word_t   out_word
);
  import rgsi_pkg::*;

  logic [2:0][COORD_W-1:0] crd;
  logic [2:0][ROT_W-1:0]   rows;

  logic                 v1_r, v2_r, v3_r;
  logic [2:0][P_W-1:0]  p1_r, p1_nxt;
  side_t                side1_r, side1_nxt, side2_r, side3_r;
  logic [2:0][2:0][PR_W-1:0] pr2_r, pr2_nxt;
  map_word_t            w3_r, w3_nxt;

  assign crd  = {in_word.out_plane, in_word.out_row, in_word.out_col};
  assign rows = {cfg.rot_row_z, cfg.rot_row_y, cfg.rot_row_x};

  // Stage 1: p = coord * spacing + offset * 16; new_ok clears if a coordinate reaches MAX_NEW_DIM.
  always_comb begin
    logic [COORD_W+SPC_F_W-1:0] cp;
    logic [OFS_F_W-1:0]         off;
    side1_nxt.new_ok = 1'b1;
    side1_nxt.plane  = in_word.out_plane;
    for (int a = 0; a < 3; a++) begin
      cp  = crd[a] * cfg.new_spacing[a*SPC_F_W +: SPC_F_W];
      off = cfg.new_offset[a*OFS_F_W +: OFS_F_W];
      p1_nxt[a] = P_W'($signed({2'b00, cp})
                  + $signed({{(P_W-OFS_F_W-4){off[OFS_F_W-1]}}, off, 4'b0000}));
      if ({1'b0, crd[a]} >= (COORD_W+1)'(MAX_NEW_DIM)) begin
        side1_nxt.new_ok = 1'b0;
      end
    end
  end

  // Stage 2: nine coefficient products.
  always_comb begin
    logic signed [PR_W-1:0] prod;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod = $signed(rows[a][k*COEF_W +: COEF_W]) * $signed(p1_r[k]);
        pr2_nxt[a][k] = prod;
      end
    end
  end

  // Stage 3: row sums, then sign and magnitude for the reciprocal multiply.
  always_comb begin
    logic signed [R_W-1:0] sum;
    for (int a = 0; a < 3; a++) begin
      sum = R_W'($signed(pr2_r[a][0])) + R_W'($signed(pr2_r[a][1]))
          + R_W'($signed(pr2_r[a][2]));
      w3_nxt.neg[a] = sum[R_W-1];
      w3_nxt.mag[a] = sum[R_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end
    w3_nxt.side = side2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    side1_r <= side1_nxt;
    pr2_r   <= pr2_nxt;
    side2_r <= side1_r;
    w3_r    <= w3_nxt;
    side3_r <= side2_r;
  end

  assign out_valid = v3_r;
  always_comb begin
    out_word      = w3_r;
    out_word.side = side3_r;
  end

endmodule

### src/rgsi_scale.sv
// Middle two stages: multiply each magnitude by the reciprocal old spacing in
// two partial products, then recombine and round to nearest, ties to even.
// Depends on rgsi_pkg.
module rgsi_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rgsi_pkg::map_word_t   in_word,
  input  rgsi_pkg::cfg_regs_t   cfg,
  output logic                  out_valid,
  output rgsi_pkg::scale_word_t out_word
);
  import rgsi_pkg::*;

  logic                   v4_r, v5_r;
  logic [2:0][LO_W-1:0]   lo4_r, lo4_nxt;
  logic [2:0][HI_W-1:0]   hi4_r, hi4_nxt;
  logic [2:0]             neg4_r;
  side_t                  side4_r;
  scale_word_t            w5_r, w5_nxt;

  // Stage 4: low and high partial products.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo4_nxt[a] = in_word.mag[a][LO_SPLIT-1:0]
                 * cfg.old_inv_spacing[a*SPC_F_W +: SPC_F_W];
      hi4_nxt[a] = in_word.mag[a][MAG_W-1:LO_SPLIT]
                 * cfg.old_inv_spacing[a*SPC_F_W +: SPC_F_W];
    end
  end

  // Stage 5: recombine, drop 40 fraction bits, round half to even.
  always_comb begin
    logic [FULL_W-1:0] full;
    logic [FRAC_W-1:0] rem;
    logic              up;
    for (int a = 0; a < 3; a++) begin
      full = (FULL_W'(hi4_r[a]) << LO_SPLIT) + FULL_W'(lo4_r[a]);
      rem  = full[FRAC_W-1:0];
      up   = rem[FRAC_W-1] & ((|rem[FRAC_W-2:0]) | full[FRAC_W]);
      w5_nxt.q[a] = Q_W'(full[FULL_W-1:FRAC_W]) + Q_W'(up);
    end
    w5_nxt.neg  = neg4_r;
    w5_nxt.side = side4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= in_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    lo4_r   <= lo4_nxt;
    hi4_r   <= hi4_nxt;
    neg4_r  <= in_word.neg;
    side4_r <= in_word.side;
    w5_r    <= w5_nxt;
  end

  assign out_valid = v5_r;
  assign out_word  = w5_r;

endmodule

### src/rgsi_index.sv
// Last three stages: bounds check against the clamped old grid, then the
// linear index plane*X*Y + row*X + col, registered as the result word.
// Depends on rgsi_pkg.
module rgsi_index #(
  parameter int MAX_OLD_DIM = rgsi_pkg::MAX_OLD_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rgsi_pkg::scale_word_t in_word,
  input  rgsi_pkg::cfg_regs_t   cfg,
  output logic                  out_valid,
  output rgsi_pkg::out_word_t   out_word
);
  import rgsi_pkg::*;

  localparam int DIM_W   = $clog2(MAX_OLD_DIM + 1);
  localparam int SRC_W   = $clog2(MAX_OLD_DIM);
  localparam int XY_W    = 2 * DIM_W;
  localparam int ROW_W   = SRC_W + DIM_W + 1;
  localparam int PROD_W  = SRC_W + XY_W;
  localparam int IDX_F_W = PROD_W + 1;
  localparam int SUM_W   = (IDX_F_W > INDEX_W) ? IDX_F_W : INDEX_W;

  logic [2:0][DIM_W-1:0] dim;

  logic                  v6_r, v7_r, v8_r;
  logic                  in6_r, in6_nxt, in7_r;
  logic [2:0][SRC_W-1:0] src6_r, src6_nxt;
  logic [SRC_W-1:0]      src2_7_r;
  logic [XY_W-1:0]       xy7_r, xy7_nxt;
  logic [ROW_W-1:0]      row7_r, row7_nxt;
  logic [SRC_W+DIM_W-1:0] mul1;
  logic [PROD_W-1:0]     prod8;
  logic [SUM_W-1:0]      idx8;
  out_word_t             w8_r, w8_nxt;

  // Old dimensions, clamped to the largest supported size.
  always_comb begin
    logic [COORD_W-1:0] d;
    for (int a = 0; a < 3; a++) begin
      d = cfg.old_dims[a*COORD_W +: COORD_W];
      dim[a] = ({1'b0, d} > (COORD_W+1)'(MAX_OLD_DIM)) ? DIM_W'(MAX_OLD_DIM)
                                                       : DIM_W'(d);
    end
  end

  // Stage 6: range check. A negative value that rounded to zero is inside.
  always_comb begin
    logic ok;
    in6_nxt = in_word.side.new_ok;
    for (int a = 0; a < 3; a++) begin
      ok = (!in_word.neg[a] || (in_word.q[a] == '0))
           && (in_word.q[a] < Q_W'(dim[a]));
      src6_nxt[a] = in_word.q[a][SRC_W-1:0];
      if (a == 2 && cfg.slice_mode) begin
        ok = Q_W'(in_word.side.plane) < Q_W'(dim[a]);
        src6_nxt[a] = in_word.side.plane[SRC_W-1:0];
      end
      in6_nxt = in6_nxt & ok;
    end
  end

  // Stage 7: plane stride and the in-plane part of the index.
  assign xy7_nxt  = dim[0] * dim[1];
  assign mul1     = src6_r[1] * dim[0];
  assign row7_nxt = ROW_W'(mul1) + ROW_W'(src6_r[0]);

  // Stage 8: add the plane part; a miss reports index zero.
  assign prod8 = src2_7_r * xy7_r;
  assign idx8  = SUM_W'(prod8) + SUM_W'(row7_r);
  always_comb begin
    w8_nxt.hit          = in7_r;
    w8_nxt.source_index = in7_r ? idx8[INDEX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v6_r <= in_valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    in6_r    <= in6_nxt;
    src6_r   <= src6_nxt;
    in7_r    <= in6_r;
    src2_7_r <= src6_r[2];
    xy7_r    <= xy7_nxt;
    row7_r   <= row7_nxt;
    w8_r     <= w8_nxt;
  end

  assign out_valid = v8_r;
  assign out_word  = w8_r;

endmodule

### src/rotated_grid_source_index.sv
// Top level of the rotated grid source index block: configuration registers
// and the map, scale and index pipeline sections.
// Depends on rgsi_pkg, rgsi_map, rgsi_scale and rgsi_index.
//
//   Channel   Ports                                Handshake
//   -------   ----------------------------------   ---------------------------
//   input     start, busy, in_word                 taken when start & !busy
//   result    out_strobe, out_word                 one cycle, no back pressure
//   config    cfg_we, cfg_index, cfg_wdata         written when cfg_we
//
// A word may be started in every cycle; busy stays low. Each result appears
// in start order, after passing through the eight register stages of the
// pipeline (three map, two scale, three index).
// rst_n is synchronous and clears the stage valid bits and the configuration
// to its defaults. The receiver cannot stall, so the pipeline never holds.
module rotated_grid_source_index #(
  parameter int MAX_OLD_DIM = rgsi_pkg::MAX_OLD_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rgsi_pkg::in_word_t               in_word,
  output logic                             out_strobe,
  output rgsi_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [rgsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgsi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rgsi_pkg::*;

  cfg_regs_t   cfg_r, cfg_nxt;
  logic        in_take;
  logic        map_valid, scale_valid;
  map_word_t   map_word;
  scale_word_t scale_word;

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROT_ROW_X:       cfg_nxt.rot_row_x       = cfg_wdata[ROT_W-1:0];
        CFG_ROT_ROW_Y:       cfg_nxt.rot_row_y       = cfg_wdata[ROT_W-1:0];
        CFG_ROT_ROW_Z:       cfg_nxt.rot_row_z       = cfg_wdata[ROT_W-1:0];
        CFG_NEW_SPACING:     cfg_nxt.new_spacing     = cfg_wdata[SPC_W-1:0];
        CFG_NEW_OFFSET:      cfg_nxt.new_offset      = cfg_wdata[OFS_W-1:0];
        CFG_OLD_INV_SPACING: cfg_nxt.old_inv_spacing = cfg_wdata[SPC_W-1:0];
        CFG_OLD_DIMS:        cfg_nxt.old_dims        = cfg_wdata[DIMS_W-1:0];
        CFG_SLICE_MODE:      cfg_nxt.slice_mode      = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_row_x       <= ROT_ROW_X_RST;
      cfg_r.rot_row_y       <= ROT_ROW_Y_RST;
      cfg_r.rot_row_z       <= ROT_ROW_Z_RST;
      cfg_r.new_spacing     <= NEW_SPC_RST;
      cfg_r.new_offset      <= NEW_OFS_RST;
      cfg_r.old_inv_spacing <= OLD_INV_RST;
      cfg_r.old_dims        <= OLD_DIMS_RST;
      cfg_r.slice_mode      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rgsi_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_take),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .out_valid (map_valid),
    .out_word  (map_word)
  );

  rgsi_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (map_valid),
    .in_word   (map_word),
    .cfg       (cfg_r),
    .out_valid (scale_valid),
    .out_word  (scale_word)
  );

  rgsi_index #(
    .MAX_OLD_DIM (MAX_OLD_DIM)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scale_valid),
    .in_word   (scale_word),
    .cfg       (cfg_r),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // A result word only comes out of a word started a full pipeline earlier.
  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_take, PIPE_LAT))
    else $error("result strobe without a matching start");

  // A miss always reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.hit) |-> (out_word.source_index == '0))
    else $error("miss with nonzero source index");

  // A hit is impossible when any old grid size is zero.
  a_hit_needs_dims: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.hit) |->
      ((cfg_r.old_dims[COORD_W-1:0] != '0)
       && (cfg_r.old_dims[2*COORD_W-1:COORD_W] != '0)
       && (cfg_r.old_dims[3*COORD_W-1:2*COORD_W] != '0)))
    else $error("hit reported with an empty old grid");
`endif

endmodule
